// ----- hw/rtl/state_change_event_log_queue_core_macros.svh -----
// ----------------------------------------------------------------------------
// State change event log queue - assertion macros
// Concurrent assertion wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STATE_CHANGE_EVENT_LOG_QUEUE_CORE_MACROS_SVH
`define STATE_CHANGE_EVENT_LOG_QUEUE_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SCELQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scelq assertion failed");
// next-cycle implication
`define SCELQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scelq assertion failed");
`else
`define SCELQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define SCELQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/scelq_pkg.sv -----
// ----------------------------------------------------------------------------
// scelq_pkg
// Shared constants, word types, codes and ring helpers of the event log queue.
// ----------------------------------------------------------------------------
package scelq_pkg;

   localparam int QUEUE_SLOTS = 16;
   localparam int IDX_W       = $clog2(QUEUE_SLOTS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int TIME_W      = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_DATA_W-1:0] STATUS_INTERVAL_RESET = 16'd2000;
   localparam logic [CSR_DATA_W-1:0] MIN_GAP_RESET         = 16'd200;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STATUS_INTERVAL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SEND_GAP    = 1'b1;

   // event codes
   localparam logic [1:0] EV_LOCKED      = 2'd0;
   localparam logic [1:0] EV_UNLOCKED    = 2'd1;
   localparam logic [1:0] EV_SECURED     = 2'd2;
   localparam logic [1:0] EV_COMPROMISED = 2'd3;

   // offer kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_EVENT  = 2'd2;

   // LED codes
   localparam logic [1:0] LED_NORMAL   = 2'd0;
   localparam logic [1:0] LED_OPEN     = 2'd1;
   localparam logic [1:0] LED_TAMPERED = 2'd2;

   localparam logic OP_REPORT = 1'b0;
   localparam logic OP_POLL   = 1'b1;

   typedef struct packed {
      logic              operation;
      logic              door_closed;
      logic              motion_seen;
      logic              enroll_busy;
      logic [TIME_W-1:0] now_ms;
      logic              accepted;
   } req_word_type;

   typedef struct packed {
      logic       led_valid;
      logic [1:0] led_code;
      logic [1:0] events_added;
      logic [1:0] oldest_dropped;
      logic [1:0] offer_kind;
      logic       offer_locked;
      logic       offer_secure;
      logic [1:0] offer_event;
      logic [3:0] queue_count;
   } rsp_word_type;

   typedef struct packed {
      logic latch;
      logic step1;
      logic step2;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(QUEUE_SLOTS - 1)) ? '0 : idx + 1'b1;
   endfunction

   // entries held, saturated at 15
   function automatic logic [3:0] ring_count(input logic [IDX_W-1:0] tail,
                                             input logic [IDX_W-1:0] head);
      logic [CNT_W-1:0] diff;
      if (tail >= head) begin
         diff = {1'b0, tail} - {1'b0, head};
      end else begin
         diff = {1'b0, tail} + CNT_W'(QUEUE_SLOTS) - {1'b0, head};
      end
      return (32'(diff) > 32'd15) ? 4'd15 : 4'(diff);
   endfunction

endpackage

// ----- hw/rtl/scelq_req_if.sv -----
// ----------------------------------------------------------------------------
// scelq_req_if
// Request channel: valid/ready handshake with report and poll fields.
// ----------------------------------------------------------------------------
interface scelq_req_if;
   import scelq_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic              door_closed;
   logic              motion_seen;
   logic              enroll_busy;
   logic [TIME_W-1:0] now_ms;
   logic              accepted;

   modport source (
      output valid, operation, door_closed, motion_seen, enroll_busy, now_ms, accepted,
      input  ready
   );
   modport sink (
      input  valid, operation, door_closed, motion_seen, enroll_busy, now_ms, accepted,
      output ready
   );
endinterface

// ----- hw/rtl/scelq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// scelq_rsp_if
// Response channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface scelq_rsp_if;
   logic       valid;
   logic       ready;
   logic       led_valid;
   logic [1:0] led_code;
   logic [1:0] events_added;
   logic [1:0] oldest_dropped;
   logic [1:0] offer_kind;
   logic       offer_locked;
   logic       offer_secure;
   logic [1:0] offer_event;
   logic [3:0] queue_count;

   modport source (
      output valid, led_valid, led_code, events_added, oldest_dropped, offer_kind,
             offer_locked, offer_secure, offer_event, queue_count,
      input  ready
   );
   modport sink (
      input  valid, led_valid, led_code, events_added, oldest_dropped, offer_kind,
             offer_locked, offer_secure, offer_event, queue_count,
      output ready
   );
endinterface

// ----- hw/rtl/scelq_ram.sv -----
// ----------------------------------------------------------------------------
// scelq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scelq_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/scelq_ctrl.sv -----
// ----------------------------------------------------------------------------
// scelq_ctrl
// Sequencer: accept a word, two ring steps, then hand off to the output reg.
// ----------------------------------------------------------------------------
module scelq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  scelq_pkg::stat_type stat,
   output scelq_pkg::cmd_type  cmd
);
   import scelq_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_STEP1 = 4'b0010,
      ST_STEP2 = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_STEP1;
            end
         end
         ST_STEP1: begin
            cmd.step1 = 1'b1;
            state_in  = ST_STEP2;
         end
         ST_STEP2: begin
            cmd.step2 = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- hw/rtl/scelq_dpath.sv -----
// ----------------------------------------------------------------------------
// scelq_dpath
// Datapath: config regs, edge detect, event ring, status latch, output reg.
// ----------------------------------------------------------------------------
module scelq_dpath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  scelq_pkg::cmd_type                      cmd,
   output scelq_pkg::stat_type                     stat,
   input  scelq_pkg::req_word_type                 req_word,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output scelq_pkg::rsp_word_type                 rsp_word,
   input  logic                                    csr_we,
   input  logic [scelq_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [scelq_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import scelq_pkg::*;

   req_word_type      in_ff;
   logic [CSR_DATA_W-1:0] interval_ff, min_gap_ff;
   logic              prev_closed_ff, prev_motion_ff;
   logic [TIME_W-1:0] last_status_ff, last_send_ff;
   logic              pend_ff, pend_locked_ff, pend_secure_ff;
   logic [IDX_W-1:0]  head_ff, tail_ff, head_in, tail_in;
   logic [1:0]        added_ff, dropped_ff;
   logic [1:0]        kind_ff, oevent_ff;
   logic              olocked_ff, osecure_ff;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_ff, rsp_in;

   logic              is_poll, push_req, do_push, ring_full, ring_empty, time_ok;
   logic [1:0]        push_ev, rd_data;
   logic [TIME_W-1:0] time_diff;
   logic [CSR_DATA_W-1:0] time_limit;

   assign is_poll    = (in_ff.operation == OP_POLL);
   assign ring_full  = (ring_next(tail_ff) == head_ff);
   assign ring_empty = (head_ff == tail_ff);

   // step 1 handles the door edge, step 2 the motion edge
   always_comb begin
      if (cmd.step1) begin
         push_req = !is_poll && (in_ff.door_closed != prev_closed_ff);
         push_ev  = in_ff.door_closed ? EV_LOCKED : EV_UNLOCKED;
      end else begin
         push_req = !is_poll && (in_ff.motion_seen != prev_motion_ff);
         push_ev  = in_ff.motion_seen ? EV_COMPROMISED : EV_SECURED;
      end
   end
   assign do_push = (cmd.step1 || cmd.step2) && push_req;

   // one wrapping subtract and compare, shared by report and poll
   assign time_diff  = in_ff.now_ms - (is_poll ? last_send_ff : last_status_ff);
   assign time_limit = is_poll ? min_gap_ff : interval_ff;
   assign time_ok    = (time_diff >= {{(TIME_W-CSR_DATA_W){1'b0}}, time_limit});

   scelq_ram #(
      .WIDTH(2),
      .DEPTH(QUEUE_SLOTS)
   ) u_ring (
      .clock  (clock),
      .wr_en  (do_push),
      .wr_addr(tail_ff),
      .wr_data(push_ev),
      .rd_addr(head_ff),
      .rd_data(rd_data)
   );

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (do_push) begin
         tail_in = ring_next(tail_ff);
         if (ring_full) begin
            head_in = ring_next(head_ff);
         end
      end else if (cmd.step2 && is_poll && time_ok && !pend_ff && !ring_empty
                   && in_ff.accepted) begin
         head_in = ring_next(head_ff);
      end
   end

   always_comb begin
      rsp_in                = '0;
      if (!is_poll && !in_ff.enroll_busy) begin
         rsp_in.led_valid = 1'b1;
         rsp_in.led_code  = in_ff.motion_seen ? LED_TAMPERED :
                            (!in_ff.door_closed ? LED_OPEN : LED_NORMAL);
      end
      rsp_in.events_added   = added_ff;
      rsp_in.oldest_dropped = dropped_ff;
      rsp_in.offer_kind     = kind_ff;
      rsp_in.offer_locked   = olocked_ff;
      rsp_in.offer_secure   = osecure_ff;
      rsp_in.offer_event    = oevent_ff;
      rsp_in.queue_count    = ring_count(tail_ff, head_ff);
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff    <= STATUS_INTERVAL_RESET;
         min_gap_ff     <= MIN_GAP_RESET;
         prev_closed_ff <= 1'b0;
         prev_motion_ff <= 1'b0;
         last_status_ff <= '0;
         last_send_ff   <= '0;
         pend_ff        <= 1'b0;
         pend_locked_ff <= 1'b0;
         pend_secure_ff <= 1'b0;
         head_ff        <= '0;
         tail_ff        <= '0;
         added_ff       <= '0;
         dropped_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STATUS_INTERVAL: interval_ff <= csr_wdata;
               CSR_MIN_SEND_GAP:    min_gap_ff  <= csr_wdata;
               default: ;
            endcase
         end
         head_ff <= head_in;
         tail_ff <= tail_in;
         if (cmd.latch) begin
            added_ff   <= '0;
            dropped_ff <= '0;
         end else if (do_push) begin
            added_ff <= added_ff + 2'd1;
            if (ring_full) begin
               dropped_ff <= dropped_ff + 2'd1;
            end
         end
         if (cmd.step2) begin
            if (!is_poll) begin
               prev_closed_ff <= in_ff.door_closed;
               prev_motion_ff <= in_ff.motion_seen;
               if (time_ok) begin
                  last_status_ff <= in_ff.now_ms;
                  pend_ff        <= 1'b1;
                  pend_locked_ff <= in_ff.door_closed;
                  pend_secure_ff <= !in_ff.motion_seen;
               end
            end else if (time_ok && in_ff.accepted && (pend_ff || !ring_empty)) begin
               last_send_ff <= in_ff.now_ms;
               if (pend_ff) begin
                  pend_ff <= 1'b0;
               end
            end
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         in_ff <= req_word;
      end
      if (cmd.step2) begin
         kind_ff    <= KIND_NONE;
         olocked_ff <= 1'b0;
         osecure_ff <= 1'b0;
         oevent_ff  <= EV_LOCKED;
         if (is_poll && time_ok) begin
            if (pend_ff) begin
               kind_ff    <= KIND_STATUS;
               olocked_ff <= pend_locked_ff;
               osecure_ff <= pend_secure_ff;
            end else if (!ring_empty) begin
               kind_ff   <= KIND_EVENT;
               oevent_ff <= rd_data;
            end
         end
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
endmodule

// ----- hw/rtl/state_change_event_log_queue_core.sv -----
// ----------------------------------------------------------------------------
// state_change_event_log_queue_core
// Sensor state-change event log with latched status and paced upload offers.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one word per sensor report (operation 0) or upload poll
//   (operation 1); rsp_chan returns exactly one result word per request word.
//   Both use valid/ready; a word moves at an edge with valid and ready high.
//   csr_we/csr_index/csr_wdata write status_interval_ms (0) and
//   min_send_gap_ms (1); write only while no request is in flight.
// Timing:
//   After acceptance the word runs two ring steps (door edge, motion edge),
//   each using the single ring write port, and the result is loaded into the
//   output register once it is free. A new request is taken once the
//   previous result is in the output register.
// Reset (synchronous, active high): ring empty, edge history and timestamps
//   cleared, config back to 2000 ms / 200 ms. Ring contents are not cleared.
// Stall: a result held in the output register does not block acceptance of
//   the next request; that request waits in the final step until the output
//   register is taken.
// ----------------------------------------------------------------------------
`include "state_change_event_log_queue_core_macros.svh"

module state_change_event_log_queue_core (
   input  logic                               clock,
   input  logic                               reset,
   scelq_req_if.sink                          req_chan,
   scelq_rsp_if.source                        rsp_chan,
   input  logic                               csr_we,
   input  logic [scelq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scelq_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import scelq_pkg::*;

   cmd_type      cmd;
   stat_type     stat;
   req_word_type req_word;
   rsp_word_type rsp_word;
   logic         rsp_valid;

   assign req_word.operation   = req_chan.operation;
   assign req_word.door_closed = req_chan.door_closed;
   assign req_word.motion_seen = req_chan.motion_seen;
   assign req_word.enroll_busy = req_chan.enroll_busy;
   assign req_word.now_ms      = req_chan.now_ms;
   assign req_word.accepted    = req_chan.accepted;

   scelq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   scelq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_chan.ready),
      .rsp_word (rsp_word),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   assign rsp_chan.valid          = rsp_valid;
   assign rsp_chan.led_valid      = rsp_word.led_valid;
   assign rsp_chan.led_code       = rsp_word.led_code;
   assign rsp_chan.events_added   = rsp_word.events_added;
   assign rsp_chan.oldest_dropped = rsp_word.oldest_dropped;
   assign rsp_chan.offer_kind     = rsp_word.offer_kind;
   assign rsp_chan.offer_locked   = rsp_word.offer_locked;
   assign rsp_chan.offer_secure   = rsp_word.offer_secure;
   assign rsp_chan.offer_event    = rsp_word.offer_event;
   assign rsp_chan.queue_count    = rsp_word.queue_count;

   // sequencer issues at most one command per cycle
   `SCELQ_ASSERT_NOW(a_cmd_onehot, clock, reset, 1'b1,
      $onehot0({cmd.latch, cmd.step1, cmd.step2, cmd.load_out}))
   // accepted word goes straight into the door step, then the motion step
   `SCELQ_ASSERT_NEXT(a_accept_step1, clock, reset,
      req_chan.valid && req_chan.ready, cmd.step1)
   `SCELQ_ASSERT_NEXT(a_step1_step2, clock, reset, cmd.step1, cmd.step2)
   // a loaded result is presented next cycle
   `SCELQ_ASSERT_NEXT(a_load_valid, clock, reset, cmd.load_out, rsp_chan.valid)
endmodule
